// ===== hw/rtl/dqec_pkg.sv =====
// ----------------------------------------------------------------------------
// dqec_pkg
// Shared types and constants for the dual quadrature encoder counter.
// ----------------------------------------------------------------------------
package dqec_pkg;

  // Fixed widths of the result fields and configuration port
  localparam int WINDOW_OUT_W  = 16;
  localparam int TOTAL_OUT_W   = 32;
  localparam int MAX_PULSES_W  = 15;
  localparam int CFG_INDEX_W   = 8;
  localparam int CFG_DATA_W    = 32;

  localparam logic [MAX_PULSES_W-1:0] MAX_PULSES_RESET = MAX_PULSES_W'(1000);

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_REVERSE_LEFT     = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] CFG_REVERSE_RIGHT    = CFG_INDEX_W'(1);
  localparam logic [CFG_INDEX_W-1:0] CFG_OVERSPEED_ENABLE = CFG_INDEX_W'(2);
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_PULSES       = CFG_INDEX_W'(3);

  typedef enum logic {
    OP_PIN_EVENT   = 1'b0,
    OP_WINDOW_TICK = 1'b1
  } opcode_t;

  // Edge flags and levels of one encoder
  typedef struct packed {
    logic a_edge;
    logic b_edge;
    logic a_level;
    logic b_level;
  } pin_t;

  // Configuration seen by one channel
  typedef struct packed {
    logic                    reverse;
    logic                    overspeed_enable;
    logic [MAX_PULSES_W-1:0] max_pulses;
  } chan_cfg_t;

  // Result of one channel for one request
  typedef struct packed {
    logic                    brake;
    logic [WINDOW_OUT_W-1:0] window;
    logic [TOTAL_OUT_W-1:0]  total;
    logic                    forward;
  } chan_result_t;

endpackage

// ===== hw/rtl/dqec_channel.sv =====
// ----------------------------------------------------------------------------
// dqec_channel
// One encoder channel: saturating window count, latch, total and direction.
// ----------------------------------------------------------------------------
module dqec_channel #(
  parameter int WINDOW_WIDTH = 16,
  parameter int TOTAL_WIDTH  = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  advance,
  input  logic                  tick,
  input  dqec_pkg::pin_t        pins,
  input  dqec_pkg::chan_cfg_t   cfg,
  output dqec_pkg::chan_result_t result
);
  import dqec_pkg::*;

  localparam int W  = WINDOW_WIDTH;
  localparam int T  = TOTAL_WIDTH;
  localparam int CW = ((W > MAX_PULSES_W) ? W : MAX_PULSES_W) + 2;

  localparam logic [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] WONE = {{(W-1){1'b0}}, 1'b1};

  logic [W-1:0] running;
  logic [W-1:0] latched;
  logic [T-1:0] accum;
  logic         dir;

  logic [W-1:0] running_next;
  logic [W-1:0] latched_next;
  logic [T-1:0] accum_next;
  logic         dir_next;

  logic [W-1:0]  after_a;
  logic [W-1:0]  after_b;
  logic [W-1:0]  closed;
  logic [CW-1:0] run_ext;
  logic [CW-1:0] lim_ext;

  function automatic logic [W-1:0] sat_step(input logic [W-1:0] v, input logic up);
    logic [W-1:0] r;
    if (up) begin
      r = (v == WMAX) ? v : v + WONE;
    end else begin
      r = (v == WMIN) ? v : v - WONE;
    end
    return r;
  endfunction

  always_comb begin
    // Apply the A step first, then the B step
    after_a = pins.a_edge ? sat_step(running, !pins.b_level) : running;
    after_b = pins.b_edge ? sat_step(after_a, pins.a_level) : after_a;

    // Negate on close when reversed; the most negative count saturates
    if (cfg.reverse) begin
      closed = (running == WMIN) ? WMAX : (~running + WONE);
    end else begin
      closed = running;
    end

    if (tick) begin
      running_next = '0;
      latched_next = closed;
      accum_next   = accum + T'({{T{closed[W-1]}}, closed});
      dir_next     = !closed[W-1];
    end else begin
      running_next = after_b;
      latched_next = latched;
      accum_next   = accum;
      dir_next     = dir;
    end

    run_ext = {{(CW-W){running_next[W-1]}}, running_next};
    lim_ext = {{(CW-MAX_PULSES_W){1'b0}}, cfg.max_pulses};

    result.brake   = cfg.overspeed_enable &&
                     (($signed(run_ext) > $signed(lim_ext)) ||
                      ($signed(run_ext) < -$signed(lim_ext)));
    result.window  = WINDOW_OUT_W'({{WINDOW_OUT_W{latched_next[W-1]}}, latched_next});
    result.total   = TOTAL_OUT_W'({{TOTAL_OUT_W{accum_next[T-1]}}, accum_next});
    result.forward = dir_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= '0;
      latched <= '0;
      accum   <= '0;
      dir     <= 1'b1;
    end else if (advance) begin
      running <= running_next;
      latched <= latched_next;
      accum   <= accum_next;
      dir     <= dir_next;
    end
  end

endmodule

// ===== hw/rtl/dual_quadrature_encoder_counter_top.sv =====
// ----------------------------------------------------------------------------
// dual_quadrature_encoder_counter_top
// Two-channel quadrature counter with window latch, totals and brake flags.
// ----------------------------------------------------------------------------
// Every request gives exactly one result. The block is an input register
// followed by one pass of counter logic into a result register; a request
// waits in the input register until the result register is free or being
// emptied. A new request can be taken on every cycle while out_ready is high.
// in_ready follows out_ready in the same cycle once both registers are full.
// A pin event moves each side's window count by one step per flagged edge
// (A step before B step, each saturating); the right encoder counts with the
// opposite polarity to the left. A window tick optionally negates each count,
// latches it, adds it to the wrapping total, records the direction and clears
// the count. The brake flags are judged on the window counts left by the
// request, so a tick always reports them low. Write configuration only while
// no request is in flight; cfg_ready is always high and register indexes
// beyond the list are dropped.
module dual_quadrature_encoder_counter_top #(
  parameter int WINDOW_WIDTH = 16,
  parameter int TOTAL_WIDTH  = 32
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // configuration write channel
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [dqec_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [dqec_pkg::CFG_DATA_W-1:0]        cfg_data,
  // request channel
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   opcode,
  input  logic                                   left_a_edge,
  input  logic                                   left_b_edge,
  input  logic                                   right_a_edge,
  input  logic                                   right_b_edge,
  input  logic                                   left_a_level,
  input  logic                                   left_b_level,
  input  logic                                   right_a_level,
  input  logic                                   right_b_level,
  // result channel
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic                                   brake_left,
  output logic                                   brake_right,
  output logic signed [dqec_pkg::WINDOW_OUT_W-1:0] left_window,
  output logic signed [dqec_pkg::WINDOW_OUT_W-1:0] right_window,
  output logic signed [dqec_pkg::TOTAL_OUT_W-1:0]  left_total,
  output logic signed [dqec_pkg::TOTAL_OUT_W-1:0]  right_total,
  output logic                                   left_forward,
  output logic                                   right_forward
);
  import dqec_pkg::*;

  // Configuration registers
  logic                    reverse_left;
  logic                    reverse_right;
  logic                    overspeed_enable;
  logic [MAX_PULSES_W-1:0] max_pulses;

  // Input register
  logic    s1_valid;
  opcode_t s1_opcode;
  pin_t    s1_left;
  pin_t    s1_right;

  logic         in_fire;
  logic         advance;
  logic         tick;
  pin_t         right_norm;
  chan_cfg_t    left_cfg;
  chan_cfg_t    right_cfg;
  chan_result_t left_res;
  chan_result_t right_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      reverse_left     <= 1'b0;
      reverse_right    <= 1'b0;
      overspeed_enable <= 1'b0;
      max_pulses       <= MAX_PULSES_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_REVERSE_LEFT:     reverse_left     <= cfg_data[0];
        CFG_REVERSE_RIGHT:    reverse_right    <= cfg_data[0];
        CFG_OVERSPEED_ENABLE: overspeed_enable <= cfg_data[0];
        CFG_MAX_PULSES:       max_pulses       <= cfg_data[MAX_PULSES_W-1:0];
        default: begin
          // drop writes beyond the register list
        end
      endcase
    end
  end

  // Advance the held request whenever the result register is free or being
  // emptied; take a new request whenever the input register will be free.
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_opcode <= opcode_t'(opcode);
      s1_left   <= '{a_edge: left_a_edge, b_edge: left_b_edge,
                     a_level: left_a_level, b_level: left_b_level};
      s1_right  <= '{a_edge: right_a_edge, b_edge: right_b_edge,
                     a_level: right_a_level, b_level: right_b_level};
    end
  end

  assign tick = (s1_opcode == OP_WINDOW_TICK);

  // The right side counts with opposite polarity: invert its levels so both
  // channels share one counting rule.
  always_comb begin
    right_norm         = s1_right;
    right_norm.a_level = !s1_right.a_level;
    right_norm.b_level = !s1_right.b_level;
  end

  assign left_cfg  = '{reverse: reverse_left, overspeed_enable: overspeed_enable,
                       max_pulses: max_pulses};
  assign right_cfg = '{reverse: reverse_right, overspeed_enable: overspeed_enable,
                       max_pulses: max_pulses};

  dqec_channel #(
    .WINDOW_WIDTH(WINDOW_WIDTH),
    .TOTAL_WIDTH (TOTAL_WIDTH)
  ) u_left (
    .clk    (clk),
    .rst    (rst),
    .advance(advance),
    .tick   (tick),
    .pins   (s1_left),
    .cfg    (left_cfg),
    .result (left_res)
  );

  dqec_channel #(
    .WINDOW_WIDTH(WINDOW_WIDTH),
    .TOTAL_WIDTH (TOTAL_WIDTH)
  ) u_right (
    .clk    (clk),
    .rst    (rst),
    .advance(advance),
    .tick   (tick),
    .pins   (right_norm),
    .cfg    (right_cfg),
    .result (right_res)
  );

  // Result register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      brake_left    <= left_res.brake;
      brake_right   <= right_res.brake;
      left_window   <= left_res.window;
      right_window  <= right_res.window;
      left_total    <= left_res.total;
      right_total   <= right_res.total;
      left_forward  <= left_res.forward;
      right_forward <= right_res.forward;
    end
  end

endmodule

// ===== hw/rtl/dqec_checker.sv =====
// ----------------------------------------------------------------------------
// dqec_checker
// Port-level checks for the dual quadrature encoder counter.
// ----------------------------------------------------------------------------
module dqec_checker #(
  parameter int WINDOW_WIDTH = 16
) (
  input logic                                    clk,
  input logic                                    rst,
  input logic                                    in_valid,
  input logic                                    in_ready,
  input logic                                    out_valid,
  input logic                                    out_ready,
  input logic signed [dqec_pkg::WINDOW_OUT_W-1:0] left_window,
  input logic signed [dqec_pkg::WINDOW_OUT_W-1:0] right_window,
  input logic signed [dqec_pkg::TOTAL_OUT_W-1:0]  left_total,
  input logic signed [dqec_pkg::TOTAL_OUT_W-1:0]  right_total,
  input logic                                    left_forward,
  input logic                                    right_forward
);
  import dqec_pkg::*;

  // Requests accepted but not yet delivered
  logic [2:0] pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + {2'b00, in_valid && in_ready}
                         - {2'b00, out_valid && out_ready};
    end
  end

  // A stalled result holds its totals
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(left_total) && $stable(right_total))
    else $error("result changed while stalled");

  // No result without an accepted request
  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready |-> pending != 3'd0)
    else $error("result delivered with no request outstanding");

  // Input and result registers hold at most two requests
  a_capacity: assert property (@(posedge clk) disable iff (rst)
    pending <= 3'd2)
    else $error("more requests outstanding than storage");

  // Direction agrees with the sign of the latched window
  a_direction: assert property (@(posedge clk) disable iff (rst)
    out_valid && (WINDOW_WIDTH <= WINDOW_OUT_W) |->
      (left_forward == !left_window[WINDOW_OUT_W-1]) &&
      (right_forward == !right_window[WINDOW_OUT_W-1]))
    else $error("direction disagrees with window sign");

endmodule

bind dual_quadrature_encoder_counter_top dqec_checker #(
  .WINDOW_WIDTH(WINDOW_WIDTH)
) u_dqec_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .left_window  (left_window),
  .right_window (right_window),
  .left_total   (left_total),
  .right_total  (right_total),
  .left_forward (left_forward),
  .right_forward(right_forward)
);

// ===== dv/dqec_count_checker.sv =====
// ----------------------------------------------------------------------------
// dqec_count_checker
// Watches the request, result and register channels of the dual quadrature
// encoder counter, predicts each result and compares it field by field.
// ----------------------------------------------------------------------------
module dqec_count_checker (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     cfg_valid,
  input  logic                                     cfg_ready,
  input  logic [dqec_pkg::CFG_INDEX_W-1:0]         cfg_index,
  input  logic [dqec_pkg::CFG_DATA_W-1:0]          cfg_data,
  input  logic                                     in_valid,
  input  logic                                     in_ready,
  input  logic                                     opcode,
  input  logic                                     left_a_edge,
  input  logic                                     left_b_edge,
  input  logic                                     right_a_edge,
  input  logic                                     right_b_edge,
  input  logic                                     left_a_level,
  input  logic                                     left_b_level,
  input  logic                                     right_a_level,
  input  logic                                     right_b_level,
  input  logic                                     out_valid,
  input  logic                                     out_ready,
  input  logic                                     brake_left,
  input  logic                                     brake_right,
  input  logic signed [dqec_pkg::WINDOW_OUT_W-1:0] left_window,
  input  logic signed [dqec_pkg::WINDOW_OUT_W-1:0] right_window,
  input  logic signed [dqec_pkg::TOTAL_OUT_W-1:0]  left_total,
  input  logic signed [dqec_pkg::TOTAL_OUT_W-1:0]  right_total,
  input  logic                                     left_forward,
  input  logic                                     right_forward,
  output int                                       fail_count,
  output int                                       outstanding,
  output int                                       results_done,
  output int                                       ticks_done,
  output int                                       brakes_done
);
  timeunit 1ns;
  timeprecision 1ps;
  import dqec_pkg::*;

  typedef logic signed [WINDOW_OUT_W-1:0] count_t;

  typedef struct {
    count_t                 running;
    count_t                 latched;
    logic [TOTAL_OUT_W-1:0] sum;
    logic                   fwd;
  } side_state_t;

  typedef struct packed {
    chan_result_t left;
    chan_result_t right;
  } pair_result_t;

  localparam count_t COUNT_MAX = {1'b0, {(WINDOW_OUT_W-1){1'b1}}};
  localparam count_t COUNT_MIN = {1'b1, {(WINDOW_OUT_W-1){1'b0}}};
  localparam side_state_t SIDE_RESET = '{running: '0, latched: '0, sum: '0, fwd: 1'b1};
  localparam chan_cfg_t CFG_RESET =
    '{reverse: 1'b0, overspeed_enable: 1'b0, max_pulses: MAX_PULSES_RESET};

  side_state_t  lside = SIDE_RESET;
  side_state_t  rside = SIDE_RESET;
  chan_cfg_t    lcfg  = CFG_RESET;
  chan_cfg_t    rcfg  = CFG_RESET;
  pair_result_t pending_snapshots[$];
  int           n_fail    = 0;
  int           n_results = 0;
  int           n_ticks   = 0;
  int           n_brakes  = 0;

  // One saturating step of a window count
  function automatic count_t nudge(count_t v, logic up);
    if (up) return (v == COUNT_MAX) ? v : count_t'(v + 1);
    return (v == COUNT_MIN) ? v : count_t'(v - 1);
  endfunction

  // A step before B step; the right encoder counts with mirrored polarity
  function automatic count_t apply_edges(count_t v, pin_t p, logic mirrored);
    count_t n;
    n = v;
    if (p.a_edge) n = nudge(n, p.b_level ^ ~mirrored);
    if (p.b_edge) n = nudge(n, p.a_level ^ mirrored);
    return n;
  endfunction

  function automatic side_state_t close_window(side_state_t s, logic rev);
    count_t d;
    d = s.running;
    if (rev) d = (d == COUNT_MIN) ? COUNT_MAX : count_t'(-d);
    s.latched = d;
    s.sum     = s.sum + {{(TOTAL_OUT_W-WINDOW_OUT_W){d[WINDOW_OUT_W-1]}}, d};
    s.fwd     = ~d[WINDOW_OUT_W-1];
    s.running = '0;
    return s;
  endfunction

  function automatic logic brake_due(count_t v, chan_cfg_t c);
    int lim;
    lim = int'(c.max_pulses);
    return c.overspeed_enable && ((int'(v) > lim) || (int'(v) < -lim));
  endfunction

  function automatic chan_result_t snapshot(side_state_t s, chan_cfg_t c);
    chan_result_t r;
    r.brake   = brake_due(s.running, c);
    r.window  = s.latched;
    r.total   = s.sum;
    r.forward = s.fwd;
    return r;
  endfunction

  task automatic check_side(string side, chan_result_t want, chan_result_t got);
    if (got.brake !== want.brake) begin
      $display("%0t: %s brake expected %0b got %0b", $time, side, want.brake, got.brake);
      n_fail++;
    end
    if (got.window !== want.window) begin
      $display("%0t: %s window expected %0d got %0d", $time, side,
               $signed(want.window), $signed(got.window));
      n_fail++;
    end
    if (got.total !== want.total) begin
      $display("%0t: %s total expected %0d got %0d", $time, side,
               $signed(want.total), $signed(got.total));
      n_fail++;
    end
    if (got.forward !== want.forward) begin
      $display("%0t: %s forward expected %0b got %0b", $time, side,
               want.forward, got.forward);
      n_fail++;
    end
  endtask

  always @(posedge clk) begin : watch
    pin_t         lp;
    pin_t         rp;
    pair_result_t want;
    pair_result_t got;
    if (rst) begin
      lside = SIDE_RESET;
      rside = SIDE_RESET;
      lcfg  = CFG_RESET;
      rcfg  = CFG_RESET;
      pending_snapshots.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_REVERSE_LEFT:  lcfg.reverse = cfg_data[0];
          CFG_REVERSE_RIGHT: rcfg.reverse = cfg_data[0];
          CFG_OVERSPEED_ENABLE: begin
            lcfg.overspeed_enable = cfg_data[0];
            rcfg.overspeed_enable = cfg_data[0];
          end
          CFG_MAX_PULSES: begin
            lcfg.max_pulses = cfg_data[MAX_PULSES_W-1:0];
            rcfg.max_pulses = cfg_data[MAX_PULSES_W-1:0];
          end
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (opcode == OP_WINDOW_TICK) begin
          lside = close_window(lside, lcfg.reverse);
          rside = close_window(rside, rcfg.reverse);
          n_ticks++;
        end else begin
          lp = {left_a_edge, left_b_edge, left_a_level, left_b_level};
          rp = {right_a_edge, right_b_edge, right_a_level, right_b_level};
          lside.running = apply_edges(lside.running, lp, 1'b0);
          rside.running = apply_edges(rside.running, rp, 1'b1);
        end
        want.left  = snapshot(lside, lcfg);
        want.right = snapshot(rside, rcfg);
        pending_snapshots.push_back(want);
      end
      if (out_valid && out_ready) begin
        n_results++;
        if (pending_snapshots.size() == 0) begin
          $display("%0t: result with no request outstanding", $time);
          n_fail++;
        end else begin
          want = pending_snapshots.pop_front();
          got.left  = {brake_left, left_window, left_total, left_forward};
          got.right = {brake_right, right_window, right_total, right_forward};
          check_side("left", want.left, got.left);
          check_side("right", want.right, got.right);
          if (brake_left || brake_right) n_brakes++;
        end
      end
    end
    fail_count   <= n_fail;
    outstanding  <= pending_snapshots.size();
    results_done <= n_results;
    ticks_done   <= n_ticks;
    brakes_done  <= n_brakes;
  end

endmodule

// ===== dv/tb_dual_quadrature_encoder_counter_top.sv =====
// ----------------------------------------------------------------------------
// tb_dual_quadrature_encoder_counter_top
// Self-checking bench for the dual quadrature encoder counter: directed
// corners, randomised encoder traffic under many register settings, a steady
// sweep of both windows up and down through the brake limit, with random
// stalls on both sides.
// ----------------------------------------------------------------------------
module tb_dual_quadrature_encoder_counter_top;
  timeunit 1ns;
  timeprecision 1ps;
  import dqec_pkg::*;

  // Generous ceiling on the length of the run
  localparam int CYCLE_LIMIT = 3_000_000;
  // Two steps per request, so this carries a window well past the sweep limit
  localparam int SWEEP_LEN   = 100;
  localparam int BURST_LEN   = 80;

  // Pin bits in order: A edge, B edge, A level, B level
  localparam pin_t PIN_IDLE    = 4'b0000;
  localparam pin_t PIN_ALL     = 4'b1111;
  localparam pin_t LEFT_CLIMB  = 4'b1110;  // A edge with B low, B edge with A high
  localparam pin_t LEFT_FALL   = 4'b1101;
  localparam pin_t RIGHT_CLIMB = 4'b1101;  // mirrored polarity on the right
  localparam pin_t RIGHT_FALL  = 4'b1110;
  localparam pin_t LEFT_BACK   = 4'b1100;  // A step up, then B step down
  localparam pin_t RIGHT_BACK  = 4'b1111;

  logic                    clk           = 1'b0;
  logic                    rst           = 1'b1;
  logic                    cfg_valid     = 1'b0;
  logic                    cfg_ready;
  logic [CFG_INDEX_W-1:0]  cfg_index     = '0;
  logic [CFG_DATA_W-1:0]   cfg_data      = '0;
  logic                    in_valid      = 1'b0;
  logic                    in_ready;
  logic                    opcode        = 1'b0;
  logic                    left_a_edge   = 1'b0;
  logic                    left_b_edge   = 1'b0;
  logic                    right_a_edge  = 1'b0;
  logic                    right_b_edge  = 1'b0;
  logic                    left_a_level  = 1'b0;
  logic                    left_b_level  = 1'b0;
  logic                    right_a_level = 1'b0;
  logic                    right_b_level = 1'b0;
  logic                    out_valid;
  logic                    out_ready     = 1'b0;
  logic                    brake_left;
  logic                    brake_right;
  logic signed [WINDOW_OUT_W-1:0] left_window;
  logic signed [WINDOW_OUT_W-1:0] right_window;
  logic signed [TOTAL_OUT_W-1:0]  left_total;
  logic signed [TOTAL_OUT_W-1:0]  right_total;
  logic                    left_forward;
  logic                    right_forward;

  int   fail_count;
  int   outstanding;
  int   results_done;
  int   ticks_done;
  int   brakes_done;

  logic       quiet       = 1'b0;   // suppress idling on both sides
  logic [1:0] left_pins   = 2'b00;  // tracked A/B levels of each encoder
  logic [1:0] right_pins  = 2'b00;
  int         settings    = 0;
  int         stall_left  = 0;
  int         cycles      = 0;

  always #6 clk = ~clk;

  dual_quadrature_encoder_counter_top DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .opcode       (opcode),
    .left_a_edge  (left_a_edge),
    .left_b_edge  (left_b_edge),
    .right_a_edge (right_a_edge),
    .right_b_edge (right_b_edge),
    .left_a_level (left_a_level),
    .left_b_level (left_b_level),
    .right_a_level(right_a_level),
    .right_b_level(right_b_level),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .brake_left   (brake_left),
    .brake_right  (brake_right),
    .left_window  (left_window),
    .right_window (right_window),
    .left_total   (left_total),
    .right_total  (right_total),
    .left_forward (left_forward),
    .right_forward(right_forward)
  );

  dqec_count_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .opcode       (opcode),
    .left_a_edge  (left_a_edge),
    .left_b_edge  (left_b_edge),
    .right_a_edge (right_a_edge),
    .right_b_edge (right_b_edge),
    .left_a_level (left_a_level),
    .left_b_level (left_b_level),
    .right_a_level(right_a_level),
    .right_b_level(right_b_level),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .brake_left   (brake_left),
    .brake_right  (brake_right),
    .left_window  (left_window),
    .right_window (right_window),
    .left_total   (left_total),
    .right_total  (right_total),
    .left_forward (left_forward),
    .right_forward(right_forward),
    .fail_count   (fail_count),
    .outstanding  (outstanding),
    .results_done (results_done),
    .ticks_done   (ticks_done),
    .brakes_done  (brakes_done)
  );

  // Result side back-pressure: drop ready in random bursts; no new burst starts while quiet
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 11);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog: abandon the run if it exceeds the cycle limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
      $display("Regression FAIL");
      $finish;
    end
  end

  // Present one request and hold it until accepted; sometimes idle first.
  // Valid stays high on return so back-to-back requests need no dip.
  task automatic issue(opcode_t op, pin_t lp, pin_t rp);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    opcode        <= op;
    left_a_edge   <= lp.a_edge;
    left_b_edge   <= lp.b_edge;
    left_a_level  <= lp.a_level;
    left_b_level  <= lp.b_level;
    right_a_edge  <= rp.a_edge;
    right_b_edge  <= rp.b_edge;
    right_a_level <= rp.a_level;
    right_b_level <= rp.b_level;
    in_valid      <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stop sending and wait until every request has produced its result.
  // Each request yields exactly one result, so nothing is left in flight.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Write all four registers with junk in the unused upper bits, and
  // optionally a stray write to an index past the end of the map
  task automatic load_settings(logic rl, logic rr, logic oe,
                               logic [MAX_PULSES_W-1:0] mp, bit stray);
    logic [CFG_DATA_W-1:0] junk;
    junk = $urandom;
    write_reg(CFG_REVERSE_LEFT, {junk[CFG_DATA_W-1:1], rl});
    junk = $urandom;
    write_reg(CFG_REVERSE_RIGHT, {junk[CFG_DATA_W-1:1], rr});
    junk = $urandom;
    write_reg(CFG_OVERSPEED_ENABLE, {junk[CFG_DATA_W-1:1], oe});
    junk = $urandom;
    write_reg(CFG_MAX_PULSES, {junk[CFG_DATA_W-1:MAX_PULSES_W], mp});
    if (stray) write_reg(CFG_INDEX_W'($urandom_range(4, 255)), $urandom);
    cfg_valid <= 1'b0;
    settings++;
  endtask

  // Plausible encoder motion: toggle one phase (rarely both, sometimes
  // neither) and report the edge along with the new pin levels
  function automatic pin_t wander(inout logic [1:0] lv);
    pin_t        p;
    int unsigned pick;
    pick = $urandom_range(0, 15);
    p    = PIN_IDLE;
    if (pick < 6 || pick == 12) begin
      lv[1]    = ~lv[1];
      p.a_edge = 1'b1;
    end
    if ((pick >= 6 && pick < 12) || pick == 12) begin
      lv[0]    = ~lv[0];
      p.b_edge = 1'b1;
    end
    p.a_level = lv[1];
    p.b_level = lv[0];
    return p;
  endfunction

  // Brake limits weighted towards values a short random walk can cross
  function automatic logic [MAX_PULSES_W-1:0] pick_limit();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return '1;
      2:       return MAX_PULSES_W'($urandom_range(1, 8));
      3:       return MAX_PULSES_W'($urandom_range(9, 40));
      default: return MAX_PULSES_W'($urandom_range(0, 32767));
    endcase
  endfunction

  // Mostly well-formed pin traffic, some ticks carrying junk, some noise
  task automatic random_burst(int count);
    pin_t        lp;
    pin_t        rp;
    int unsigned pick;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        issue(OP_WINDOW_TICK, pin_t'(4'($urandom)), pin_t'(4'($urandom)));
      end else if (pick < 18) begin
        issue(OP_PIN_EVENT, pin_t'(4'($urandom)), pin_t'(4'($urandom)));
      end else begin
        lp = wander(left_pins);
        rp = wander(right_pins);
        issue(OP_PIN_EVENT, lp, rp);
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: idle, A edge alone, B edge with A high, all bits set and both
    // edges with low levels on both encoders, then ticks with all fields set and clear
    issue(OP_PIN_EVENT, PIN_IDLE, PIN_IDLE);
    issue(OP_PIN_EVENT, pin_t'(4'b1000), pin_t'(4'b1000));
    issue(OP_PIN_EVENT, pin_t'(4'b0110), pin_t'(4'b0110));
    issue(OP_PIN_EVENT, PIN_ALL, PIN_ALL);
    issue(OP_PIN_EVENT, pin_t'(4'b1100), pin_t'(4'b1100));
    issue(OP_WINDOW_TICK, PIN_ALL, PIN_ALL);
    issue(OP_WINDOW_TICK, PIN_IDLE, PIN_IDLE);

    // Zero limit with both reversals: a single step brakes, ticks negate
    settle();
    load_settings(1'b1, 1'b1, 1'b1, '0, 1'b1);
    issue(OP_PIN_EVENT, pin_t'(4'b1000), pin_t'(4'b1001));
    issue(OP_WINDOW_TICK, PIN_IDLE, PIN_IDLE);
    issue(OP_PIN_EVENT, pin_t'(4'b0100), pin_t'(4'b0100));
    issue(OP_PIN_EVENT, PIN_IDLE, PIN_IDLE);
    issue(OP_WINDOW_TICK, PIN_ALL, PIN_IDLE);

    // Widest limit, right side reversed only
    settle();
    load_settings(1'b0, 1'b1, 1'b1, '1, 1'b1);
    issue(OP_PIN_EVENT, pin_t'(4'b1000), pin_t'(4'b0110));
    issue(OP_WINDOW_TICK, PIN_IDLE, PIN_ALL);

    // Random traffic under a new setting per burst; the first two pin the
    // limit to its extremes and one burst runs without idling
    for (int k = 0; k < 10; k++) begin
      settle();
      quiet <= (k == 4);
      case (k)
        0:       load_settings(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b1,
                               '0, 1'($urandom_range(0, 1)));
        1:       load_settings(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b1,
                               '1, 1'($urandom_range(0, 1)));
        default: load_settings(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                               1'($urandom_range(0, 1)), pick_limit(),
                               1'($urandom_range(0, 1)));
      endcase
      random_burst(BURST_LEN);
    end

    // Drive both windows up through the brake limit, step A before B on one
    // request, tick, then drive both down through the negative limit and
    // tick again, with the left side reversed for the whole sweep
    settle();
    quiet <= 1'b0;
    load_settings(1'b1, 1'b0, 1'b1, MAX_PULSES_W'(150), 1'b0);
    repeat (SWEEP_LEN) issue(OP_PIN_EVENT, LEFT_CLIMB, RIGHT_CLIMB);
    issue(OP_PIN_EVENT, LEFT_BACK, RIGHT_BACK);
    issue(OP_PIN_EVENT, LEFT_CLIMB, RIGHT_CLIMB);
    issue(OP_WINDOW_TICK, PIN_IDLE, PIN_IDLE);
    repeat (SWEEP_LEN) issue(OP_PIN_EVENT, LEFT_FALL, RIGHT_FALL);
    issue(OP_WINDOW_TICK, PIN_IDLE, PIN_IDLE);

    // Closing stretch at full rate: no idling on either side from here on
    settle();
    quiet <= 1'b1;
    load_settings(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b1,
                  MAX_PULSES_W'($urandom_range(1, 8)), 1'b1);
    random_burst(100);

    // Drain, then allow the two-stage pipeline to fall silent
    settle();
    repeat (4) @(posedge clk);

    $display("Checked %0d results, %0d of them window ticks, over %0d register settings.",
             results_done, ticks_done, settings);
    $display("Brake flags high in %0d results; both windows swept through the brake limit.",
             brakes_done);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/dqec_pkg.sv
hw/rtl/dqec_channel.sv
hw/rtl/dual_quadrature_encoder_counter_top.sv
hw/rtl/dqec_checker.sv
dv/dqec_count_checker.sv
dv/tb_dual_quadrature_encoder_counter_top.sv
